>>> rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) else $error(msg);

`endif

>>> rtl/core/cens_pkg.sv
`timescale 1ns / 1ps

package cens_pkg;

  localparam int unsigned OpcodeW   = 2;
  localparam int unsigned SlotW     = 11;
  localparam int unsigned WordW     = 64;
  localparam int unsigned FoundW    = 12;
  localparam int unsigned DistW     = 7;

  // Opcodes
  localparam logic [OpcodeW-1:0] OP_WRITE   = 2'd0;
  localparam logic [OpcodeW-1:0] OP_EXACT   = 2'd1;
  localparam logic [OpcodeW-1:0] OP_NEAREST = 2'd2;

  typedef struct packed {
    logic [OpcodeW-1:0] opcode;
    logic [SlotW-1:0]   entry_index;
    logic [WordW-1:0]   word_value;
  } in_t;

  typedef struct packed {
    logic [FoundW-1:0] found_index;
    logic              hit;
    logic [DistW-1:0]  distance;
  } out_t;

endpackage

>>> rtl/core/cam_exact_and_nearest_search.sv
`timescale 1ns / 1ps

// Table of ENTRIES stored words of KEY_WIDTH bits with three operations per input
// transaction: write one slot, exact lookup (first slot equal to the key, or miss code
// 2*ENTRIES-1 masked to 12 bits with hit low) and nearest lookup (lowest slot of least
// Hamming distance, with that distance). Every input transaction yields exactly one
// output transaction. A write or an unused opcode loads its answer into the output
// register on acceptance. A lookup sweeps the whole table through a single read port,
// one slot per clock, into one shared compare / popcount unit. Each word passes the
// read register, one popcount stage and one compare stage; the result then waits for
// the output register. in_ready_o stays low for the whole sweep. A new transaction
// is taken only while the output register is empty or being claimed in that same
// cycle, so a result left waiting holds off the next transaction. Slots are undefined
// after reset; every slot must be written before any lookup. Writes to slots >= ENTRIES
// are dropped but still echo the slot number.
module cam_exact_and_nearest_search #(
  parameter int unsigned ENTRIES   = 2048,
  parameter int unsigned KEY_WIDTH = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cens_pkg::in_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cens_pkg::out_t out_data_o
);

  `include "assert_macros.svh"

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned NumBytes = (KEY_WIDTH + 7) / 8;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);
  localparam logic [cens_pkg::FoundW-1:0] MissCode =
    cens_pkg::FoundW'((2 * ENTRIES - 1) % 4096);
  localparam logic [cens_pkg::DistW-1:0] DistInit = cens_pkg::DistW'(KEY_WIDTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e state_q;

  // Control
  logic        out_valid_q;
  logic        issue_on_q;
  logic        s1_valid_q, s1_last_q;
  logic        s2_valid_q, s2_last_q;
  logic        found_q;
  logic [IdxW-1:0] cnt_q;

  // Datapath
  logic [cens_pkg::OpcodeW-1:0] op_q;
  logic [KEY_WIDTH-1:0]         key_q;
  logic [KEY_WIDTH-1:0]         rd_data_q;
  logic [IdxW-1:0]              s1_idx_q, s2_idx_q;
  logic                         s2_eq_q;
  logic [3:0]                   s2_cnt_q [NumBytes];
  logic [IdxW-1:0]              found_idx_q, best_idx_q;
  logic [cens_pkg::DistW-1:0]   best_q;
  cens_pkg::out_t               out_q;

  logic [KEY_WIDTH-1:0] mem_q [ENTRIES];

  logic                 in_fire, out_free, out_set;
  logic                 is_lookup;
  logic                 wr_en;
  logic [IdxW-1:0]      wr_addr;
  logic [31:0]          slot_ext;
  logic [NumBytes*8-1:0] diff_pad;
  logic [3:0]           byte_cnt [NumBytes];
  logic [cens_pkg::DistW-1:0] dist_sum;
  cens_pkg::out_t       imm_res, scan_res;
  logic [31:0]          found_ext, best_ext;

  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign is_lookup = in_data_i.opcode inside {cens_pkg::OP_EXACT, cens_pkg::OP_NEAREST};

  // output register loads: immediate answer, or end of a sweep
  assign out_set = (in_fire && !is_lookup) || ((state_q == ST_DONE) && out_free);

  assign slot_ext = 32'(in_data_i.entry_index);
  assign wr_addr  = slot_ext[IdxW-1:0];
  assign wr_en    = in_fire && (in_data_i.opcode == cens_pkg::OP_WRITE) &&
                    (slot_ext < ENTRIES);

  // Table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= in_data_i.word_value[KEY_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[cnt_q];
  end

  // Stage 1: per-byte popcount of key xor entry
  always_comb begin
    diff_pad = '0;
    diff_pad[KEY_WIDTH-1:0] = rd_data_q ^ key_q;
    for (int b = 0; b < NumBytes; b++) begin
      byte_cnt[b] = '0;
      for (int k = 0; k < 8; k++) begin
        byte_cnt[b] = byte_cnt[b] + 4'(diff_pad[b*8+k]);
      end
    end
  end

  // Stage 2: sum of byte counts
  always_comb begin
    dist_sum = '0;
    for (int b = 0; b < NumBytes; b++) begin
      dist_sum = dist_sum + cens_pkg::DistW'(s2_cnt_q[b]);
    end
  end

  // Immediate answer for write / unused opcode
  always_comb begin
    imm_res = '0;
    case (in_data_i.opcode)
      cens_pkg::OP_WRITE: begin
        imm_res.found_index = {1'b0, in_data_i.entry_index};
      end
      default: begin
        imm_res = '0;
      end
    endcase
  end

  always_comb begin
    found_ext = 32'(found_idx_q);
    best_ext  = 32'(best_idx_q);
    scan_res  = '0;
    case (op_q)
      cens_pkg::OP_EXACT: begin
        scan_res.found_index = found_q ? found_ext[cens_pkg::FoundW-1:0] : MissCode;
        scan_res.hit         = found_q;
      end
      cens_pkg::OP_NEAREST: begin
        scan_res.found_index = best_ext[cens_pkg::FoundW-1:0];
        scan_res.hit         = 1'b1;
        scan_res.distance    = best_q;
      end
      default: begin
        scan_res = '0;
      end
    endcase
  end

  // Sequencer, pipeline control and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      issue_on_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
      s1_last_q   <= 1'b0;
      s2_valid_q  <= 1'b0;
      s2_last_q   <= 1'b0;
      found_q     <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (out_set) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      s1_valid_q <= issue_on_q;
      s1_last_q  <= issue_on_q && (cnt_q == LastIdx);
      s2_valid_q <= s1_valid_q;
      s2_last_q  <= s1_last_q;

      case (state_q)
        ST_IDLE: begin
          if (in_fire && is_lookup) begin
            state_q    <= ST_SCAN;
            issue_on_q <= 1'b1;
            cnt_q      <= '0;
            found_q    <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (issue_on_q) begin
            if (cnt_q == LastIdx) begin
              issue_on_q <= 1'b0;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
          if (s2_valid_q && s2_eq_q) begin
            found_q <= 1'b1;
          end
          if (s2_valid_q && s2_last_q) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    s1_idx_q <= cnt_q;
    s2_idx_q <= s1_idx_q;
    s2_eq_q  <= (rd_data_q == key_q);
    for (int b = 0; b < NumBytes; b++) begin
      s2_cnt_q[b] <= byte_cnt[b];
    end

    if (in_fire) begin
      op_q   <= in_data_i.opcode;
      key_q  <= in_data_i.word_value[KEY_WIDTH-1:0];
      best_q <= DistInit;
      if (!is_lookup) begin
        out_q <= imm_res;
      end
    end

    if (state_q == ST_SCAN && s2_valid_q) begin
      // first exact hit wins; strict less keeps the lowest slot on ties
      if (s2_eq_q && !found_q) begin
        found_idx_q <= s2_idx_q;
      end
      if (dist_sum < best_q) begin
        best_q     <= dist_sum;
        best_idx_q <= s2_idx_q;
      end
    end

    if (state_q == ST_DONE && out_free) begin
      out_q <= scan_res;
    end
  end

  // Assertions
  `ASSERT_PROP(a_lookup_busy, clk_i, rst_ni, in_fire && is_lookup |=> !in_ready_o,
               "ready high right after a lookup was taken")
  `ASSERT_NEVER(a_pipe_outside_scan, clk_i, rst_ni, s2_valid_q && state_q != ST_SCAN,
                "scan pipeline active outside a lookup")
  `ASSERT_PROP(a_dist_needs_hit, clk_i, rst_ni,
               out_valid_o && out_data_o.distance != '0 |-> out_data_o.hit,
               "nonzero distance without hit")
  `ASSERT_PROP(a_best_bounded, clk_i, rst_ni,
               state_q == ST_DONE && op_q == cens_pkg::OP_NEAREST |->
               best_q <= cens_pkg::DistW'(KEY_WIDTH),
               "nearest lookup finished without a candidate")

endmodule

>>> tb/search_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the search table, keeps its own copy of the stored
// words, and checks every result transaction against the oldest prediction.
module search_checker #(
  parameter int unsigned ENTRIES   = 2048,
  parameter int unsigned KEY_WIDTH = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  cens_pkg::in_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  cens_pkg::out_t out_data_i,
  output int unsigned    error_count_o,
  output int unsigned    open_count_o
);

  localparam logic [cens_pkg::WordW-1:0] KeyMask =
    {cens_pkg::WordW{1'b1}} >> (cens_pkg::WordW - KEY_WIDTH);
  localparam int unsigned MissFull = 2 * ENTRIES - 1;
  localparam int unsigned MissCode = MissFull % (1 << cens_pkg::FoundW);

  logic [cens_pkg::WordW-1:0] slot_words [ENTRIES];
  cens_pkg::out_t             awaited_answers [$];
  int unsigned                mismatches;

  function automatic cens_pkg::out_t search_table(cens_pkg::in_t req);
    cens_pkg::out_t             ans;
    int unsigned                best;
    int unsigned                gap;
    logic [cens_pkg::WordW-1:0] key;
    ans  = '0;
    key  = req.word_value & KeyMask;
    best = KEY_WIDTH + 1;
    case (req.opcode)
      cens_pkg::OP_WRITE: begin
        ans.found_index = {1'b0, req.entry_index};
      end
      cens_pkg::OP_EXACT: begin
        ans.found_index = cens_pkg::FoundW'(MissCode);
        // walk downward so the lowest matching slot is the one left standing
        for (int i = ENTRIES - 1; i >= 0; i--) begin
          if ((slot_words[i] & KeyMask) == key) begin
            ans.found_index = cens_pkg::FoundW'(i);
            ans.hit         = 1'b1;
          end
        end
      end
      cens_pkg::OP_NEAREST: begin
        for (int i = 0; i < ENTRIES; i++) begin
          gap = $countones((slot_words[i] ^ key) & KeyMask);
          if (gap < best) begin
            best            = gap;
            ans.found_index = cens_pkg::FoundW'(i);
          end
        end
        ans.hit      = 1'b1;
        ans.distance = cens_pkg::DistW'(best);
      end
      default: ;
    endcase
    return ans;
  endfunction

  always @(posedge clk_i) begin : watch
    cens_pkg::out_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (awaited_answers.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing pending: idx %0d hit %0b dist %0d", $time,
                   out_data_i.found_index, out_data_i.hit, out_data_i.distance);
        end else begin
          want = awaited_answers.pop_front();
          if (out_data_i.found_index !== want.found_index || out_data_i.hit !== want.hit ||
              out_data_i.distance !== want.distance) begin
            mismatches++;
            $display({"%0t: mismatch: expected idx %0d hit %0b dist %0d,",
                      " got idx %0d hit %0b dist %0d"},
                     $time, want.found_index, want.hit, want.distance,
                     out_data_i.found_index, out_data_i.hit, out_data_i.distance);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        awaited_answers.push_back(search_table(in_data_i));
        if (in_data_i.opcode == cens_pkg::OP_WRITE && in_data_i.entry_index < ENTRIES) begin
          slot_words[in_data_i.entry_index] = in_data_i.word_value & KeyMask;
        end
      end
    end
    error_count_o = mismatches;
    open_count_o  = awaited_answers.size();
  end

endmodule

>>> tb/cam_exact_and_nearest_search_test.sv
`timescale 1ns / 1ps

// Top of the search table bench. Only makes stimulus and gives the verdict;
// prediction and checking live in search_checker.
module cam_exact_and_nearest_search_test;

  localparam int unsigned ENTRIES   = 2048;
  localparam int unsigned KEY_WIDTH = 64;

  // opcode 3 has no name in the package
  localparam logic [cens_pkg::OpcodeW-1:0] OP_UNUSED = 2'd3;
  localparam logic [cens_pkg::WordW-1:0]   ALL_ONES  = {cens_pkg::WordW{1'b1}};

  // handshake pressure profiles
  typedef enum logic [1:0] {
    FLOW_FREE,
    FLOW_SRC_IDLE,
    FLOW_SINK_STALL,
    FLOW_BOTH
  } flow_e;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_ready;
  cens_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_ready;
  cens_pkg::out_t out_data;
  int unsigned    error_count;
  int unsigned    open_count;
  flow_e          flow;

  // what the bench has written, used only to aim keys and rewrites at real content
  logic [cens_pkg::WordW-1:0] shadow_words [ENTRIES];

  cam_exact_and_nearest_search #(
    .ENTRIES  (ENTRIES),
    .KEY_WIDTH(KEY_WIDTH)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  search_checker #(
    .ENTRIES  (ENTRIES),
    .KEY_WIDTH(KEY_WIDTH)
  ) watch (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .error_count_o(error_count),
    .open_count_o (open_count)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Result side: ready is rerolled every falling edge, so stalls land on
  // any cycle of a lookup sweep or right as the result comes out.
  always @(negedge clk) begin : sink_ready
    int unsigned stall_pct;
    stall_pct = (flow == FLOW_SINK_STALL) ? 77 : (flow == FLOW_BOTH) ? 36 : 0;
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Hard stop. Worst case is every random transaction a full sweep plus two
  // table fills; this is several times that.
  initial begin
    #30_000_000;
    $display("cam_exact_and_nearest_search_test: FAIL");
    $finish;
  end

  // Called on a falling edge; returns on the falling edge after acceptance
  // with valid still high so the next transaction can follow back to back.
  task automatic send_op(input logic [cens_pkg::OpcodeW-1:0] opcode,
                         input logic [cens_pkg::SlotW-1:0] slot,
                         input logic [cens_pkg::WordW-1:0] word);
    int unsigned   idle_pct;
    cens_pkg::in_t item;
    idle_pct         = (flow == FLOW_SRC_IDLE) ? 77 : (flow == FLOW_BOTH) ? 36 : 0;
    item.opcode      = opcode;
    item.entry_index = slot;
    item.word_value  = word;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (opcode == cens_pkg::OP_WRITE) shadow_words[slot] = word;
  endtask

  // Drop valid and hold off until every result is back.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (open_count != 0) @(negedge clk);
  endtask

  function automatic logic [cens_pkg::WordW-1:0] flip_bits(logic [cens_pkg::WordW-1:0] w);
    repeat ($urandom_range(3, 1)) w = w ^ (64'd1 << $urandom_range(cens_pkg::WordW - 1));
    return w;
  endfunction

  // Every slot has to hold a word before any lookup, since a sweep reads them all.
  // Scrambled fills copy an earlier slot now and then, so exact hits see duplicates.
  task automatic fill_table(input bit scramble);
    logic [cens_pkg::WordW-1:0] word;
    for (int s = 0; s < ENTRIES; s++) begin
      if (!scramble) word = '0;
      else if (s > 0 && $urandom_range(9) == 0) word = shadow_words[$urandom_range(s - 1)];
      else word = {$urandom, $urandom};
      send_op(cens_pkg::OP_WRITE, cens_pkg::SlotW'(s), word);
    end
  endtask

  // Random mix: writes reuse or perturb stored words to build duplicates and
  // near ties; most lookup keys are aimed at stored content so that hits and small
  // distances dominate, the rest are random, the two extremes or inverted stored words.
  task automatic run_phase(input flow_e mode, input int unsigned count);
    int unsigned                  pick;
    logic [cens_pkg::OpcodeW-1:0] opcode;
    logic [cens_pkg::SlotW-1:0]   slot;
    logic [cens_pkg::WordW-1:0]   word;
    flow = mode;
    repeat (count) begin
      pick   = $urandom_range(99);
      slot   = cens_pkg::SlotW'($urandom_range(ENTRIES - 1));
      opcode = (pick < 37) ? cens_pkg::OP_WRITE : (pick < 62) ? cens_pkg::OP_EXACT :
               (pick < 92) ? cens_pkg::OP_NEAREST : OP_UNUSED;
      pick   = $urandom_range(99);
      if (opcode == cens_pkg::OP_WRITE) begin
        if (pick < 40) word = {$urandom, $urandom};
        else if (pick < 70) word = shadow_words[$urandom_range(ENTRIES - 1)];
        else word = flip_bits(shadow_words[$urandom_range(ENTRIES - 1)]);
      end else begin
        if (pick < 35) word = shadow_words[$urandom_range(ENTRIES - 1)];
        else if (pick < 60) word = flip_bits(shadow_words[$urandom_range(ENTRIES - 1)]);
        else if (pick < 80) word = {$urandom, $urandom};
        else if (pick < 85) word = '0;
        else if (pick < 90) word = ALL_ONES;
        else word = ~shadow_words[$urandom_range(ENTRIES - 1)];
      end
      send_op(opcode, slot, word);
    end
    hold_until_drained();
  endtask

  initial begin
    flow      = FLOW_FREE;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // All-zero table first: every slot ties, so lowest-index rules are exposed.
    fill_table(1'b0);

    send_op(cens_pkg::OP_NEAREST, '0, ALL_ONES);                 // all at distance 64
    send_op(cens_pkg::OP_EXACT, '1, '0);                         // first of 2048 equal
    send_op(cens_pkg::OP_EXACT, '0, ALL_ONES);                   // miss code
    send_op(OP_UNUSED, '1, ALL_ONES);                            // unused opcode, ones
    send_op(cens_pkg::OP_WRITE, '1, ALL_ONES);                   // top slot
    send_op(cens_pkg::OP_EXACT, '0, ALL_ONES);                   // match only in top slot
    send_op(cens_pkg::OP_NEAREST, '0, ALL_ONES);                 // distance 0 at top slot
    send_op(cens_pkg::OP_WRITE, '0, 64'h8000_0000_0000_0000);    // high bit only
    send_op(cens_pkg::OP_NEAREST, '0, 64'hFFFF_FFFF_0000_0000);  // popcount in upper half
    send_op(cens_pkg::OP_EXACT, '0, 64'h8000_0000_0000_0000);
    send_op(cens_pkg::OP_WRITE, 11'd1024, 64'h0000_0000_FFFF_FFFF);
    send_op(cens_pkg::OP_NEAREST, '1, 64'h0000_0001_FFFF_FFFF);  // distance 1, index ignored
    send_op(cens_pkg::OP_EXACT, '0, '0);                         // slot 0 no longer zero
    send_op(OP_UNUSED, '0, '0);                                  // unused opcode, all zero
    send_op(cens_pkg::OP_EXACT, '0, 64'h0000_0000_FFFF_FFFF);
    send_op(cens_pkg::OP_WRITE, 11'h555, 64'hAAAA_AAAA_AAAA_AAAA);
    send_op(cens_pkg::OP_NEAREST, 11'h2AA, 64'h5555_5555_5555_5555);
    send_op(cens_pkg::OP_EXACT, 11'h2AA, 64'hAAAA_AAAA_AAAA_AAAA);

    // Sender waits here for every outstanding result.
    hold_until_drained();

    // Random contents, loaded under mixed pressure on both sides.
    flow = FLOW_BOTH;
    fill_table(1'b1);
    hold_until_drained();

    run_phase(FLOW_FREE, 72);
    run_phase(FLOW_SRC_IDLE, 72);
    run_phase(FLOW_SINK_STALL, 72);
    run_phase(FLOW_BOTH, 74);

    // Quiet tail: nothing pending, ready held high, catch any stray result.
    flow = FLOW_FREE;
    repeat (ENTRIES + 16) @(negedge clk);

    if (error_count == 0) begin
      $display("cam_exact_and_nearest_search_test: PASS");
    end else begin
      $display("cam_exact_and_nearest_search_test: FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/cens_pkg.sv
rtl/core/cam_exact_and_nearest_search.sv
tb/search_checker.sv
tb/cam_exact_and_nearest_search_test.sv
